>>> rtl/htg_pkg.sv
// shared types and constants of the helix trajectory generator
// holds the rotation cell bus, register indexes, fixed-point constants and output saturation
// no dependencies
package htg_pkg;

  // width of the rotation datapath (x, y and residual angle)
  localparam int XW = 34;

  // register indexes on the configuration port
  localparam logic [2:0] REG_DURATION = 3'd0;
  localparam logic [2:0] REG_INV_DUR  = 3'd1;
  localparam logic [2:0] REG_RADIUS   = 3'd2;
  localparam logic [2:0] REG_CLIMB    = 3'd3;
  localparam logic [2:0] REG_BASE_X   = 3'd4;
  localparam logic [2:0] REG_BASE_Y   = 3'd5;
  localparam logic [2:0] REG_BASE_Z   = 3'd6;
  // index with no register behind it
  localparam logic [2:0] REG_SPARE    = 3'd7;

  // state handed from one rotation cell to the next
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
    logic                 flip;
  } htg_rot_t;

  // starting x of the rotation, pre-scaled by the inverse rotation gain, q.30
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

  // 2*pi in q.30
  localparam logic signed [33:0] TWO_PI_Q30 = 34'sd6746518852;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    hi_lim = 64'sd2147483647;
    lo_lim = -64'sd2147483648;
    if (v > hi_lim) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo_lim) begin
      return 32'sh80000000;
    end else begin
      return 32'(v);
    end
  endfunction

endpackage

>>> rtl/htg_delay.sv
// fixed-length delay line with a shared advance enable
// carries operands alongside the multiplier and rotation stages
// depends on nothing
module htg_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  // shift taps on every advance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule

>>> rtl/htg_mul.sv
// two-stage signed multiplier, product shifted right truncating toward zero
// the second operand is split in two halves so each partial product stays narrow
// depends on nothing
module htg_mul #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int SH = 30,
  parameter int WO = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [WA-1:0] a_i,
  input  logic signed [WB-1:0] b_i,
  output logic signed [WO-1:0] p_o
);

  localparam int BL = WB / 2;
  localparam int BH = WB - BL;
  localparam int WP = WA + WB;

  logic [WA-1:0]         a_mag;
  logic [WB-1:0]         b_mag;
  logic [WA+BL-1:0]      plo_q;
  logic [WA+BH-1:0]      phi_q;
  logic                  neg_q;
  logic [WP-1:0]         prod;
  logic [WP-1:0]         shifted;
  logic signed [WP:0]    res;
  logic signed [WO-1:0]  p_q;

  // operand magnitudes
  always_comb begin
    a_mag = a_i[WA-1] ? WA'(-a_i) : WA'(a_i);
    b_mag = b_i[WB-1] ? WB'(-b_i) : WB'(b_i);
  end

  // first stage: two partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q <= a_mag * b_mag[BL-1:0];
      phi_q <= a_mag * b_mag[WB-1:BL];
      neg_q <= a_i[WA-1] ^ b_i[WB-1];
    end
  end

  // second stage: combine, shift, restore sign
  always_comb begin
    prod    = {phi_q, {BL{1'b0}}} + WP'(plo_q);
    shifted = prod >> SH;
    res     = neg_q ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= WO'(res);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/htg_cordic_cell.sv
// one rotation cell of the sine/cosine chain, registered output
// rotates by the arctangent of 2^-IDX toward zero residual angle
// depends on htg_pkg
module htg_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  htg_pkg::htg_rot_t rot_i,
  output htg_pkg::htg_rot_t rot_o
);

  import htg_pkg::*;

  // arctangent of 2^-i in turns, q0.32
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    case (idx)
      5'd0:    return 32'h20000000;
      5'd1:    return 32'h12E4051E;
      5'd2:    return 32'h09FB385B;
      5'd3:    return 32'h051111D4;
      5'd4:    return 32'h028B0D43;
      5'd5:    return 32'h0145D7E1;
      5'd6:    return 32'h00A2F61E;
      5'd7:    return 32'h00517C55;
      5'd8:    return 32'h0028BE53;
      5'd9:    return 32'h00145F2F;
      5'd10:   return 32'h000A2F98;
      5'd11:   return 32'h000517CC;
      5'd12:   return 32'h00028BE6;
      5'd13:   return 32'h000145F3;
      5'd14:   return 32'h0000A2FA;
      5'd15:   return 32'h0000517D;
      5'd16:   return 32'h000028BE;
      5'd17:   return 32'h0000145F;
      5'd18:   return 32'h00000A30;
      5'd19:   return 32'h00000518;
      5'd20:   return 32'h0000028C;
      5'd21:   return 32'h00000146;
      5'd22:   return 32'h000000A3;
      5'd23:   return 32'h00000051;
      5'd24:   return 32'h00000029;
      5'd25:   return 32'h00000014;
      5'd26:   return 32'h0000000A;
      5'd27:   return 32'h00000005;
      5'd28:   return 32'h00000003;
      5'd29:   return 32'h00000001;
      5'd30:   return 32'h00000001;
      default: return 32'h00000000;
    endcase
  endfunction

  localparam logic signed [XW-1:0] ATAN = XW'(atan_turn(5'(IDX)));

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  htg_rot_t             rot_d;
  htg_rot_t             rot_q;

  // micro-rotation, direction from the sign of the residual angle
  always_comb begin
    xs = rot_i.x >>> IDX;
    ys = rot_i.y >>> IDX;
    rot_d.flip = rot_i.flip;
    if (rot_i.z >= 0) begin
      rot_d.x = rot_i.x - ys;
      rot_d.y = rot_i.y + xs;
      rot_d.z = rot_i.z - ATAN;
    end else begin
      rot_d.x = rot_i.x + ys;
      rot_d.y = rot_i.y - xs;
      rot_d.z = rot_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

>>> rtl/helix_trajectory_generator_top.sv
// Helix trajectory generator: turns one elapsed-time item into the position, velocity and
// acceleration set-point of a one-turn helix on a quintic rest-to-rest blend, all q16.16.
// Fully pipelined: one item enters per clock unless the output holds back the pipe. Each
// item passes the chain of ANGLE_STAGES rotation cells and the two-stage multipliers
// around it. A finished result waiting on the output does not stop intake as long as the
// stage in front of the output register is empty. Configuration is to be written over
// the APB port only while no item is in flight; the block itself does not enforce this.
// depends on htg_pkg, htg_mul, htg_delay and htg_cordic_cell
module helix_trajectory_generator_top #(
  parameter int FRAC_BITS    = 16,
  parameter int ANGLE_STAGES = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input item
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // elapsed_time
  // result item
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                                       // acc_x, acc_y, acc_z (32 bits each)
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  import htg_pkg::*;

  localparam int N     = ANGLE_STAGES;
  localparam int DEPTH = N + 12;

  localparam logic signed [35:0] POLY_TEN = 36'sd10737418240;
  localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;

  // configuration registers
  logic [31:0]        dur_q;
  logic [31:0]        inv_q;
  logic [30:0]        rad_q;
  logic signed [31:0] climb_q;
  logic signed [31:0] bx_q;
  logic signed [31:0] by_q;
  logic signed [31:0] bz_q;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q   <= 32'd524288;
      inv_q   <= 32'd536870912;
      rad_q   <= 31'd131072;
      climb_q <= 32'sd163840;
      bx_q    <= '0;
      by_q    <= '0;
      bz_q    <= 32'sd65536;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DURATION: dur_q   <= pwdata;
        REG_INV_DUR:  inv_q   <= pwdata;
        REG_RADIUS:   rad_q   <= pwdata[30:0];
        REG_CLIMB:    climb_q <= pwdata;
        REG_BASE_X:   bx_q    <= pwdata;
        REG_BASE_Y:   by_q    <= pwdata;
        REG_BASE_Z:   bz_q    <= pwdata;
        default:      ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_DURATION: prdata = dur_q;
      REG_INV_DUR:  prdata = inv_q;
      REG_RADIUS:   prdata = {1'b0, rad_q};
      REG_CLIMB:    prdata = climb_q;
      REG_BASE_X:   prdata = bx_q;
      REG_BASE_Y:   prdata = by_q;
      REG_BASE_Z:   prdata = bz_q;
      default:      prdata = '0;
    endcase
  end

  // pipeline advance and valid tags
  logic             pipe_en;
  logic             in_acc;
  logic [DEPTH-1:0] vld_q;
  logic [DEPTH-1:0] vld_d;
  logic             out_load;
  logic             m_valid_q;
  logic [287:0]     m_data_q;
  logic [287:0]     m_data_d;

  assign pipe_en       = !m_valid_q | m_axis_tready | !vld_q[DEPTH-1];
  assign s_axis_tready = pipe_en;
  assign in_acc        = s_axis_tvalid & pipe_en;
  assign vld_d         = {vld_q[DEPTH-2:0], in_acc};
  assign out_load      = !m_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= vld_d;
    end
  end

  // normalized time s = t / T, saturated below one
  logic [31:0]        t_in;
  logic               done_0;
  logic signed [65:0] ts_2;
  logic [31:0]        s32_2;
  logic [29:0]        s_2;
  logic [30:0]        u_2;

  assign t_in   = s_axis_tdata;
  assign done_0 = t_in >= dur_q;

  htg_mul #(.WA(33), .WB(33), .SH(FRAC_BITS), .WO(66)) u_mul_s (
    .clk_i, .en_i(pipe_en),
    .a_i($signed({1'b0, t_in})), .b_i($signed({1'b0, inv_q})), .p_o(ts_2)
  );

  always_comb begin
    s32_2 = (|ts_2[65:32]) ? 32'hFFFFFFFF : ts_2[31:0];
    s_2   = s32_2[31:2];
    u_2   = 31'd1073741824 - {1'b0, s_2};
  end

  // blend powers and derivative factors
  logic signed [30:0] s2_4;
  logic signed [29:0] su_4;
  logic [29:0]        s_4;
  logic signed [35:0] poly_4;
  logic signed [31:0] dif_4;

  htg_mul #(.WA(31), .WB(31), .SH(30), .WO(31)) u_mul_s2 (
    .clk_i, .en_i(pipe_en),
    .a_i($signed({1'b0, s_2})), .b_i($signed({1'b0, s_2})), .p_o(s2_4)
  );

  htg_mul #(.WA(31), .WB(32), .SH(30), .WO(30)) u_mul_su (
    .clk_i, .en_i(pipe_en),
    .a_i($signed({1'b0, s_2})), .b_i($signed({1'b0, u_2})), .p_o(su_4)
  );

  htg_delay #(.W(30), .N(2)) u_dly_s (
    .clk_i, .en_i(pipe_en), .d_i(s_2), .q_o(s_4)
  );

  always_comb begin
    poly_4 = POLY_TEN - $signed({6'd0, s_4}) * 36'sd15 + 36'(s2_4) * 36'sd6;
    dif_4  = ONE_Q30 - $signed({1'b0, s_4, 1'b0});
  end

  logic signed [30:0] s3_6;
  logic signed [29:0] sq_6;
  logic signed [29:0] m6_6;
  logic [35:0]        poly_6_raw;
  logic signed [35:0] poly_6;
  logic signed [31:0] qd_6;
  logic signed [35:0] qdd_6;

  htg_mul #(.WA(31), .WB(31), .SH(30), .WO(31)) u_mul_s3 (
    .clk_i, .en_i(pipe_en),
    .a_i(s2_4), .b_i($signed({1'b0, s_4})), .p_o(s3_6)
  );

  htg_mul #(.WA(30), .WB(30), .SH(30), .WO(30)) u_mul_sq (
    .clk_i, .en_i(pipe_en), .a_i(su_4), .b_i(su_4), .p_o(sq_6)
  );

  htg_mul #(.WA(30), .WB(32), .SH(30), .WO(30)) u_mul_dd (
    .clk_i, .en_i(pipe_en), .a_i(su_4), .b_i(dif_4), .p_o(m6_6)
  );

  htg_delay #(.W(36), .N(2)) u_dly_poly (
    .clk_i, .en_i(pipe_en), .d_i(poly_4), .q_o(poly_6_raw)
  );

  // times 30 and times 60 by shift and subtract
  always_comb begin
    poly_6 = $signed(poly_6_raw);
    qd_6   = (32'(sq_6) <<< 5) - (32'(sq_6) <<< 1);
    qdd_6  = (36'(m6_6) <<< 6) - (36'(m6_6) <<< 2);
  end

  // blend value and its time derivatives
  logic signed [32:0] q_8;
  logic signed [32:0] qdt_8;
  logic signed [35:0] tmp_8;

  htg_mul #(.WA(31), .WB(36), .SH(30), .WO(33)) u_mul_q (
    .clk_i, .en_i(pipe_en), .a_i(s3_6), .b_i(poly_6), .p_o(q_8)
  );

  htg_mul #(.WA(32), .WB(33), .SH(32), .WO(33)) u_mul_qdt (
    .clk_i, .en_i(pipe_en), .a_i(qd_6), .b_i($signed({1'b0, inv_q})), .p_o(qdt_8)
  );

  htg_mul #(.WA(33), .WB(36), .SH(32), .WO(36)) u_mul_qdd1 (
    .clk_i, .en_i(pipe_en), .a_i($signed({1'b0, inv_q})), .b_i(qdd_6), .p_o(tmp_8)
  );

  // angle in turns, folded into the right half plane
  logic [31:0] phase_8;
  logic [31:0] phase_sum;
  logic [31:0] phase_f;
  logic        flip_8;
  htg_rot_t    rot_chain [N+1];

  always_comb begin
    phase_8   = {q_8[29:0], 2'b00};
    phase_sum = phase_8 + 32'h40000000;
    flip_8    = phase_sum[31];
    phase_f   = flip_8 ? phase_8 + 32'h80000000 : phase_8;
    rot_chain[0].x    = CORDIC_GAIN;
    rot_chain[0].y    = '0;
    rot_chain[0].z    = XW'($signed(phase_f));
    rot_chain[0].flip = flip_8;
  end

  // chain of rotation cells
  for (genvar k = 0; k < N; k++) begin : g_rot
    htg_cordic_cell #(.IDX(k)) u_cell (
      .clk_i, .en_i(pipe_en), .rot_i(rot_chain[k]), .rot_o(rot_chain[k+1])
    );
  end

  // second-level products on the blend side
  logic signed [35:0] qddt_10;
  logic signed [35:0] bd_10;
  logic signed [33:0] hq_10;
  logic signed [33:0] vz_10;

  htg_mul #(.WA(33), .WB(36), .SH(32), .WO(36)) u_mul_qdd2 (
    .clk_i, .en_i(pipe_en), .a_i($signed({1'b0, inv_q})), .b_i(tmp_8), .p_o(qddt_10)
  );

  htg_mul #(.WA(33), .WB(34), .SH(30), .WO(36)) u_mul_bd (
    .clk_i, .en_i(pipe_en), .a_i(qdt_8), .b_i(TWO_PI_Q30), .p_o(bd_10)
  );

  htg_mul #(.WA(32), .WB(33), .SH(30), .WO(34)) u_mul_hq (
    .clk_i, .en_i(pipe_en), .a_i(climb_q), .b_i(q_8), .p_o(hq_10)
  );

  htg_mul #(.WA(32), .WB(33), .SH(30), .WO(34)) u_mul_vz (
    .clk_i, .en_i(pipe_en), .a_i(climb_q), .b_i(qdt_8), .p_o(vz_10)
  );

  logic signed [38:0] bdd_12;
  logic signed [39:0] bd2_12;
  logic signed [36:0] az_12;

  htg_mul #(.WA(34), .WB(36), .SH(30), .WO(39)) u_mul_bdd (
    .clk_i, .en_i(pipe_en), .a_i(TWO_PI_Q30), .b_i(qddt_10), .p_o(bdd_12)
  );

  htg_mul #(.WA(36), .WB(36), .SH(30), .WO(40)) u_mul_bd2 (
    .clk_i, .en_i(pipe_en), .a_i(bd_10), .b_i(bd_10), .p_o(bd2_12)
  );

  htg_mul #(.WA(32), .WB(36), .SH(30), .WO(37)) u_mul_az (
    .clk_i, .en_i(pipe_en), .a_i(climb_q), .b_i(qddt_10), .p_o(az_12)
  );

  // line up the blend side with the end of the rotation chain
  logic [35:0] bd_c;
  logic [38:0] bdd_c;
  logic [39:0] bd2_c;
  logic [33:0] hq_e;
  logic [33:0] vz_e;
  logic [36:0] az_e;
  logic        done_e;

  htg_delay #(.W(36), .N(N)) u_dly_bd (
    .clk_i, .en_i(pipe_en), .d_i(bd_10), .q_o(bd_c)
  );

  htg_delay #(.W(39), .N(N-2)) u_dly_bdd (
    .clk_i, .en_i(pipe_en), .d_i(bdd_12), .q_o(bdd_c)
  );

  htg_delay #(.W(40), .N(N-2)) u_dly_bd2 (
    .clk_i, .en_i(pipe_en), .d_i(bd2_12), .q_o(bd2_c)
  );

  htg_delay #(.W(34), .N(N+2)) u_dly_hq (
    .clk_i, .en_i(pipe_en), .d_i(hq_10), .q_o(hq_e)
  );

  htg_delay #(.W(34), .N(N+2)) u_dly_vz (
    .clk_i, .en_i(pipe_en), .d_i(vz_10), .q_o(vz_e)
  );

  htg_delay #(.W(37), .N(N)) u_dly_az (
    .clk_i, .en_i(pipe_en), .d_i(az_12), .q_o(az_e)
  );

  htg_delay #(.W(1), .N(DEPTH)) u_dly_done (
    .clk_i, .en_i(pipe_en), .d_i(done_0), .q_o(done_e)
  );

  // cosine and sine, scaled by the radius
  logic signed [XW-1:0] cos_r;
  logic signed [XW-1:0] sin_r;
  logic signed [33:0]   rc_c;
  logic signed [33:0]   rs_c;

  always_comb begin
    cos_r = rot_chain[N].flip ? -rot_chain[N].x : rot_chain[N].x;
    sin_r = rot_chain[N].flip ? -rot_chain[N].y : rot_chain[N].y;
  end

  htg_mul #(.WA(32), .WB(XW), .SH(30), .WO(34)) u_mul_rc (
    .clk_i, .en_i(pipe_en), .a_i($signed({1'b0, rad_q})), .b_i(cos_r), .p_o(rc_c)
  );

  htg_mul #(.WA(32), .WB(XW), .SH(30), .WO(34)) u_mul_rs (
    .clk_i, .en_i(pipe_en), .a_i($signed({1'b0, rad_q})), .b_i(sin_r), .p_o(rs_c)
  );

  // chain-rule products for velocity and acceleration
  logic signed [37:0] v_rsbd;
  logic signed [37:0] v_rcbd;
  logic signed [41:0] a_rcbd2;
  logic signed [41:0] a_rsbd2;
  logic signed [40:0] a_rsbdd;
  logic signed [40:0] a_rcbdd;
  logic [33:0]        rc_e;
  logic [33:0]        rs_e;

  htg_mul #(.WA(34), .WB(36), .SH(30), .WO(38)) u_mul_vx (
    .clk_i, .en_i(pipe_en), .a_i(rs_c), .b_i($signed(bd_c)), .p_o(v_rsbd)
  );

  htg_mul #(.WA(34), .WB(36), .SH(30), .WO(38)) u_mul_vy (
    .clk_i, .en_i(pipe_en), .a_i(rc_c), .b_i($signed(bd_c)), .p_o(v_rcbd)
  );

  htg_mul #(.WA(34), .WB(40), .SH(30), .WO(42)) u_mul_ax1 (
    .clk_i, .en_i(pipe_en), .a_i(rc_c), .b_i($signed(bd2_c)), .p_o(a_rcbd2)
  );

  htg_mul #(.WA(34), .WB(39), .SH(30), .WO(41)) u_mul_ax2 (
    .clk_i, .en_i(pipe_en), .a_i(rs_c), .b_i($signed(bdd_c)), .p_o(a_rsbdd)
  );

  htg_mul #(.WA(34), .WB(40), .SH(30), .WO(42)) u_mul_ay1 (
    .clk_i, .en_i(pipe_en), .a_i(rs_c), .b_i($signed(bd2_c)), .p_o(a_rsbd2)
  );

  htg_mul #(.WA(34), .WB(39), .SH(30), .WO(41)) u_mul_ay2 (
    .clk_i, .en_i(pipe_en), .a_i(rc_c), .b_i($signed(bdd_c)), .p_o(a_rcbdd)
  );

  htg_delay #(.W(34), .N(2)) u_dly_rc (
    .clk_i, .en_i(pipe_en), .d_i(rc_c), .q_o(rc_e)
  );

  htg_delay #(.W(34), .N(2)) u_dly_rs (
    .clk_i, .en_i(pipe_en), .d_i(rs_c), .q_o(rs_e)
  );

  // final sums, saturation and the finished-move case
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] acc_z;

  always_comb begin
    if (done_e) begin
      pos_x = sat32(64'($signed({1'b0, rad_q})) + 64'(bx_q));
      pos_y = by_q;
      pos_z = sat32(64'(climb_q) + 64'(bz_q));
      vel_x = '0;
      vel_y = '0;
      vel_z = '0;
      acc_x = '0;
      acc_y = '0;
      acc_z = '0;
    end else begin
      pos_x = sat32(64'($signed(rc_e)) + 64'(bx_q));
      pos_y = sat32(64'($signed(rs_e)) + 64'(by_q));
      pos_z = sat32(64'($signed(hq_e)) + 64'(bz_q));
      vel_x = sat32(-64'(v_rsbd));
      vel_y = sat32(64'(v_rcbd));
      vel_z = sat32(64'($signed(vz_e)));
      acc_x = sat32(-64'(a_rcbd2) - 64'(a_rsbdd));
      acc_y = sat32(-64'(a_rsbd2) + 64'(a_rcbdd));
      acc_z = sat32(64'($signed(az_e)));
    end
    m_data_d = {acc_z, acc_y, acc_x, vel_z, vel_y, vel_x, pos_z, pos_y, pos_x};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> bench/tb_helix_trajectory_generator_top.sv
// self-checking bench for the helix trajectory generator: drives time items over the stream
// port, programs the move over apb and checks every set-point against a bit-true predictor
// depends on helix_trajectory_generator_top and htg_pkg
module tb_helix_trajectory_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import htg_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int ANGLE_STAGES = 24;
  localparam int LATENCY      = ANGLE_STAGES + 13;
  localparam int QI           = 30;
  localparam longint ONE_QI   = 64'sd1 << QI;
  localparam longint TWO_PI   = 64'sd6746518852;
  localparam longint GAIN     = 64'sd652032874;
  localparam logic [127:0] MAG_LIMIT = 128'h1 << 61;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;   // elapsed_time
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // predictor copy of the move registers
  logic [31:0] move_dur, move_inv, move_rad, move_climb, move_bx, move_by, move_bz;

  logic [287:0] setpoint_q [$];
  int mismatch_cnt = 0;
  int orphan_cnt = 0;
  int result_cnt = 0;
  int item_cnt;
  int burst_left;
  int ready_pct = 100;

  helix_trajectory_generator_top #(
    .FRAC_BITS   (FRAC_BITS),
    .ANGLE_STAGES(ANGLE_STAGES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // exact product magnitude, shifted right and clamped, sign restored
  function automatic longint scaled_mul(input longint a, input longint b, input int n);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] r;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 64'(-a) : 64'(a);
    ub  = (b < 0) ? 64'(-b) : 64'(b);
    r   = ({64'b0, ua} * {64'b0, ub}) >> n;
    if (r > MAG_LIMIT) r = MAG_LIMIT;
    return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // rotation on a turn phase, cos and sin in q.30
  function automatic void turn_rotate(input logic [31:0] phase, output longint c,
                                      output longint sn);
    logic   flip;
    longint x, y, z, nx;
    flip = phase[31] ^ phase[30];
    if (flip) phase = phase + 32'h80000000;
    x = GAIN;
    y = 0;
    z = longint'(signed'(phase));
    for (int i = 0; i < ANGLE_STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    c  = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  // set-point of the helix for one elapsed time
  function automatic logic [287:0] helix_setpoint(input logic [31:0] t);
    longint r, h, bx, by, bz, it;
    logic [63:0] s32;
    longint sv, u, s2, s3, poly, q, su, qd, qdd, qdt, qddt;
    longint c, sn, rc, rs, bd, bdd, bd2;
    logic [31:0] f [9];
    r  = longint'({1'b0, move_rad[30:0]});
    h  = longint'(signed'(move_climb));
    bx = longint'(signed'(move_bx));
    by = longint'(signed'(move_by));
    bz = longint'(signed'(move_bz));
    it = longint'({32'b0, move_inv});
    if (t >= move_dur) begin
      f[0] = clamp32(r + bx);
      f[1] = clamp32(by);
      f[2] = clamp32(h + bz);
      for (int j = 3; j < 9; j++) f[j] = '0;
    end else begin
      s32 = ({32'b0, t} * {32'b0, move_inv}) >> FRAC_BITS;
      if (s32 > 64'hFFFFFFFF) s32 = 64'hFFFFFFFF;
      sv   = longint'(s32 >> 2);
      u    = ONE_QI - sv;
      s2   = scaled_mul(sv, sv, QI);
      s3   = scaled_mul(s2, sv, QI);
      poly = 10 * ONE_QI - 15 * sv + 6 * s2;
      q    = scaled_mul(s3, poly, QI);
      su   = scaled_mul(sv, u, QI);
      qd   = 30 * scaled_mul(su, su, QI);
      qdd  = 60 * scaled_mul(su, ONE_QI - 2 * sv, QI);
      qdt  = scaled_mul(qd, it, 32);
      qddt = scaled_mul(scaled_mul(qdd, it, 32), it, 32);
      turn_rotate(32'(q << 2), c, sn);
      rc  = scaled_mul(r, c, QI);
      rs  = scaled_mul(r, sn, QI);
      bd  = scaled_mul(TWO_PI, qdt, QI);
      bdd = scaled_mul(TWO_PI, qddt, QI);
      bd2 = scaled_mul(bd, bd, QI);
      f[0] = clamp32(rc + bx);
      f[1] = clamp32(rs + by);
      f[2] = clamp32(scaled_mul(h, q, QI) + bz);
      f[3] = clamp32(-scaled_mul(rs, bd, QI));
      f[4] = clamp32(scaled_mul(rc, bd, QI));
      f[5] = clamp32(scaled_mul(h, qdt, QI));
      f[6] = clamp32(-scaled_mul(rc, bd2, QI) - scaled_mul(rs, bdd, QI));
      f[7] = clamp32(-scaled_mul(rs, bd2, QI) + scaled_mul(rc, bdd, QI));
      f[8] = clamp32(scaled_mul(h, qddt, QI));
    end
    return {f[8], f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
  endfunction

  // apb write, also updates the predictor copy
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_DURATION: move_dur   = value;
      REG_INV_DUR:  move_inv   = value;
      REG_RADIUS:   move_rad   = {1'b0, value[30:0]};
      REG_CLIMB:    move_climb = value;
      REG_BASE_X:   move_bx    = value;
      REG_BASE_Y:   move_by    = value;
      REG_BASE_Z:   move_bz    = value;
      default: ;
    endcase
  endtask

  // program a whole move; inverse given explicitly
  task automatic load_move(input logic [31:0] dur, input logic [31:0] inv,
                           input logic [31:0] rad, input logic [31:0] climb,
                           input logic [31:0] bx, input logic [31:0] by,
                           input logic [31:0] bz);
    write_reg(REG_DURATION, dur);
    write_reg(REG_INV_DUR, inv);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_CLIMB, climb);
    write_reg(REG_BASE_X, bx);
    write_reg(REG_BASE_Y, by);
    write_reg(REG_BASE_Z, bz);
  endtask

  function automatic logic [31:0] inverse_of(input logic [31:0] dur);
    logic [63:0] v;
    v = (64'h1 << 48) / {32'b0, dur};
    return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
  endfunction

  // send one time item in bursts; expectation is queued when the handshake is certain
  task automatic send_time(input logic [31:0] t, input logic known,
                           input logic [287:0] known_val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    setpoint_q.push_back(known ? known_val : helix_setpoint(t));
    item_cnt++;
    @(posedge clk_i);
    burst_left--;
  endtask

  // wait until every queued result has come back, then let the pipe drain
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (setpoint_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // random time item: mostly inside the move, some after its end
  function automatic logic [31:0] pick_time();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return (move_dur > 1) ? 32'($urandom_range(0, move_dur - 1)) : 32'd0;
    if (sel < 85) return $urandom();
    if (sel < 92) return move_dur - 32'($urandom_range(0, 3));
    return move_dur + 32'($urandom_range(0, 3));
  endfunction

  // receiver stall pattern: the ready duty changes now and then at random
  always @(posedge clk_i) begin
    if (($urandom_range(0, 299)) == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 80;
        2: ready_pct = 40;
        default: ready_pct = 15;
      endcase
    end
    m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  // result checker, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk_i) begin
    logic [287:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_cnt++;
      if (setpoint_q.size() == 0) begin
        orphan_cnt++;
        if (mismatch_cnt + orphan_cnt <= 10) $display("result with nothing expected");
      end else begin
        want = setpoint_q.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (m_axis_tdata[k*32 +: 32] !== want[k*32 +: 32]) begin
            mismatch_cnt++;
            if (mismatch_cnt + orphan_cnt <= 10)
              $display("field %0d mismatch: expected %h, got %h", k,
                       want[k*32 +: 32], m_axis_tdata[k*32 +: 32]);
          end
        end
      end
    end
  end

  // time limit
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  typedef struct {
    logic [31:0]  t;
    logic         known;
    logic [287:0] val;
  } time_row_t;

  // main sequence
  initial begin
    time_row_t rows [$];
    logic [287:0] at_rest;
    logic [31:0]  d;
    int per_phase;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    burst_left = 0;
    item_cnt = 0;
    move_dur = 32'd524288;
    move_inv = 32'd536870912;
    move_rad = 32'd131072;
    move_climb = 32'd163840;
    move_bx = 32'd0;
    move_by = 32'd0;
    move_bz = 32'd65536;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows on the reset move: finished move read off directly
    at_rest = {192'b0, 32'd229376, 32'd0, 32'd131072};
    rows.push_back('{32'hFFFFFFFF, 1'b1, at_rest});
    rows.push_back('{32'd524288, 1'b1, at_rest});
    rows.push_back('{32'd524289, 1'b1, at_rest});
    rows.push_back('{32'h80000000, 1'b1, at_rest});
    rows.push_back('{32'h7FFFFFFF, 1'b1, at_rest});
    rows.push_back('{32'd0, 1'b0, '0});
    rows.push_back('{32'd1, 1'b0, '0});
    rows.push_back('{32'd524287, 1'b0, '0});
    rows.push_back('{32'd262144, 1'b0, '0});
    rows.push_back('{32'd131072, 1'b0, '0});
    rows.push_back('{32'd393216, 1'b0, '0});
    rows.push_back('{32'h0000FFFF, 1'b0, '0});
    rows.push_back('{32'h00055555, 1'b0, '0});
    rows.push_back('{32'h0002AAAA, 1'b0, '0});
    foreach (rows[i]) send_time(rows[i].t, rows[i].known, rows[i].val);
    drain();

    // extreme moves, then randomized ones
    per_phase = 1950 / 10;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: load_move(32'd65536, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        1: load_move(32'hFFFFFFFF, 32'd1, 32'd0, 32'h80000000,
                     32'h80000000, 32'h80000000, 32'h80000000);
        2: load_move(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                     32'd0, 32'd0, 32'd0);
        3: load_move(32'd65536, 32'd1, 32'hFFFFFFFF, 32'd65536,
                     32'h80000000, 32'h7FFFFFFF, 32'd0);
        default: begin
          d = (ph % 2) ? 32'($urandom_range(65536, 32'h00400000)) : $urandom();
          if (d < 65536) d = 65536;
          load_move(d, ($urandom_range(0, 3) == 0) ? $urandom() | 32'd1 : inverse_of(d),
                    $urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 1 << 20)),
                    $urandom_range(0, 3) == 0 ? $urandom()
                                              : 32'($urandom_range(0, 1 << 20)) - (1 << 19),
                    $urandom(), $urandom(), $urandom());
        end
      endcase
      // unmapped address must leave every register alone
      write_reg(REG_SPARE, $urandom());
      for (int n = 0; n < per_phase; n++) send_time(pick_time(), 1'b0, '0);
      drain();
    end

    $display("sent %0d time items over 11 move settings, %0d set-points checked", item_cnt,
             result_cnt);
    $display("moves covered extreme durations, inverses, radii, heights and offsets");
    if (mismatch_cnt == 0 && orphan_cnt == 0 && setpoint_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d unexpected results", mismatch_cnt, orphan_cnt);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
